>>> rtl/fsmp_pkg.sv
// Package for the framed serial message parser: shared types, codes and constants.
// Used by every module of the parser; depends on nothing.
package fsmp_pkg;

  // Frame start marker and the count of length bytes that are not payload.
  localparam logic [7:0] FRAME_MARK   = 8'h23;
  localparam logic [7:0] LEN_OVERHEAD = 8'd2;

  // Input item codes.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes and reset values.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT = 2'd2;

  localparam logic [7:0] MIN_LENGTH_RST = 8'd2;
  localparam logic [7:0] MAX_LENGTH_RST = 8'd66;
  localparam logic [5:0] IDLE_LIMIT_RST = 6'd50;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN  = 3'd1,
    PH_SEQ  = 3'd2,
    PH_CMD  = 3'd3,
    PH_BODY = 3'd4,
    PH_SKIP = 3'd5
  } phase_t;

  // Configuration register set.
  typedef struct packed {
    logic [7:0] min_length;
    logic [7:0] max_length;
    logic [5:0] idle_limit;
  } cfg_t;

  // One input beat.
  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       frame_done;
    logic       frame_ok;
    logic [7:0] frame_seq;
    logic [7:0] frame_cmd;
    logic [7:0] frame_length;
  } out_item_t;

  // Handshake between the input register and the result register.
  typedef struct packed {
    logic valid;
    logic fire;
  } stage_ctl_t;

endpackage

>>> rtl/fsmp_ifs.sv
// Valid/ready channel interfaces for the parser's input and result beats.
// Field widths follow the constants and types of fsmp_pkg.
interface fsmp_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface fsmp_out_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic       frame_done;
  logic       frame_ok;
  logic [7:0] frame_seq;
  logic [7:0] frame_cmd;
  logic [7:0] frame_length;

  modport source (
    output valid, output payload_valid, output payload_byte, output payload_index,
    output frame_done, output frame_ok, output frame_seq, output frame_cmd,
    output frame_length, input ready
  );
  modport sink (
    input valid, input payload_valid, input payload_byte, input payload_index,
    input frame_done, input frame_ok, input frame_seq, input frame_cmd,
    input frame_length, output ready
  );
endinterface

>>> rtl/fsmp_cfg_regs.sv
// Configuration registers of the parser, written through a plain write port.
// Depends on fsmp_pkg for register indexes and reset values.
module fsmp_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [fsmp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_wdata,
  output fsmp_pkg::cfg_t                cfg
);

  fsmp_pkg::cfg_t cfg_r;
  fsmp_pkg::cfg_t cfg_nxt;

  // Register decode; indexes beyond the list are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        fsmp_pkg::CFG_MIN_LENGTH: cfg_nxt.min_length = cfg_wdata;
        fsmp_pkg::CFG_MAX_LENGTH: cfg_nxt.max_length = cfg_wdata;
        fsmp_pkg::CFG_IDLE_LIMIT: cfg_nxt.idle_limit = cfg_wdata[5:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_length <= fsmp_pkg::MIN_LENGTH_RST;
      cfg_r.max_length <= fsmp_pkg::MAX_LENGTH_RST;
      cfg_r.idle_limit <= fsmp_pkg::IDLE_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/fsmp_in_stage.sv
// Input register of the parser: captures one beat from the input channel.
// Depends on fsmp_pkg and the fsmp_in_if interface.
module fsmp_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  fsmp_in_if.sink              in_ch,
  input  logic                 advance,
  output logic                 s1_valid,
  output fsmp_pkg::in_item_t   s1_item
);

  logic               valid_r;
  logic               valid_nxt;
  fsmp_pkg::in_item_t item_r;
  logic               accept;

  // A new beat enters when the register is empty or drains this cycle.
  assign in_ch.ready = !valid_r || advance;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.op      <= in_ch.op;
      item_r.rx_byte <= in_ch.rx_byte;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

>>> rtl/fsmp_core.sv
// Frame parser state machine and per-beat result logic.
// Depends on fsmp_pkg; state advances once per beat handed to the result register.
module fsmp_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fsmp_pkg::stage_ctl_t ctl,
  input  fsmp_pkg::in_item_t   item,
  input  fsmp_pkg::cfg_t       cfg,
  output fsmp_pkg::out_item_t  res
);

  fsmp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] count_r, count_nxt;
  logic [7:0] exp_len_r, exp_len_nxt;
  logic [7:0] seq_r, seq_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [5:0] idle_r, idle_nxt;
  logic [7:0] ch;

  assign ch = item.rx_byte;

  // Next-state logic.
  always_comb begin
    phase_nxt   = phase_r;
    sum_nxt     = sum_r;
    count_nxt   = count_r;
    exp_len_nxt = exp_len_r;
    seq_nxt     = seq_r;
    cmd_nxt     = cmd_r;
    idle_nxt    = idle_r;
    if (item.op == fsmp_pkg::OP_TICK) begin
      // Saturating idle count; reaching the limit forces hunting.
      if (idle_r < cfg.idle_limit) begin
        idle_nxt = idle_r + 6'd1;
      end
      if (idle_nxt >= cfg.idle_limit) begin
        phase_nxt = fsmp_pkg::PH_HUNT;
      end
    end else begin
      idle_nxt = '0;
      unique case (phase_r)
        fsmp_pkg::PH_HUNT: begin
          if (ch == fsmp_pkg::FRAME_MARK) begin
            phase_nxt = fsmp_pkg::PH_LEN;
            sum_nxt   = '0;
            count_nxt = '0;
          end
        end
        fsmp_pkg::PH_LEN: begin
          if (ch < cfg.min_length) begin
            phase_nxt = fsmp_pkg::PH_HUNT;
          end else if (ch <= cfg.max_length) begin
            exp_len_nxt = ch - fsmp_pkg::LEN_OVERHEAD;
            sum_nxt     = sum_r + ch;
            phase_nxt   = fsmp_pkg::PH_SEQ;
          end else begin
            exp_len_nxt = ch;
            phase_nxt   = fsmp_pkg::PH_SKIP;
          end
        end
        fsmp_pkg::PH_SEQ: begin
          seq_nxt   = ch;
          sum_nxt   = sum_r + ch;
          phase_nxt = fsmp_pkg::PH_CMD;
        end
        fsmp_pkg::PH_CMD: begin
          cmd_nxt   = ch;
          sum_nxt   = sum_r + ch;
          phase_nxt = fsmp_pkg::PH_BODY;
        end
        fsmp_pkg::PH_BODY: begin
          if (count_r < exp_len_r) begin
            count_nxt = count_r + 8'd1;
            sum_nxt   = sum_r + ch;
          end else begin
            phase_nxt = fsmp_pkg::PH_HUNT;
          end
        end
        fsmp_pkg::PH_SKIP: begin
          // An oversized frame is dropped after L+1 further bytes.
          if (count_r == exp_len_r) begin
            phase_nxt = fsmp_pkg::PH_HUNT;
          end
          count_nxt = count_r + 8'd1;
        end
        default: phase_nxt = fsmp_pkg::PH_HUNT;
      endcase
    end
  end

  // Result logic: a payload beat or a frame report, otherwise all zero.
  always_comb begin
    res = '0;
    if (item.op == fsmp_pkg::OP_BYTE && phase_r == fsmp_pkg::PH_BODY) begin
      if (count_r < exp_len_r) begin
        res.payload_valid = 1'b1;
        res.payload_byte  = ch;
        res.payload_index = count_r;
      end else begin
        res.frame_done   = 1'b1;
        res.frame_ok     = (sum_r == ch);
        res.frame_seq    = seq_r;
        res.frame_cmd    = cmd_r;
        res.frame_length = exp_len_r + fsmp_pkg::LEN_OVERHEAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= fsmp_pkg::PH_HUNT;
      sum_r     <= '0;
      count_r   <= '0;
      exp_len_r <= '0;
      seq_r     <= '0;
      cmd_r     <= '0;
      idle_r    <= '0;
    end else if (ctl.valid && ctl.fire) begin
      phase_r   <= phase_nxt;
      sum_r     <= sum_nxt;
      count_r   <= count_nxt;
      exp_len_r <= exp_len_nxt;
      seq_r     <= seq_nxt;
      cmd_r     <= cmd_nxt;
      idle_r    <= idle_nxt;
    end
  end

endmodule

>>> rtl/fsmp_out_stage.sv
// Result register of the parser, driving the result channel.
// Depends on fsmp_pkg and the fsmp_out_if interface.
module fsmp_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 s1_valid,
  input  fsmp_pkg::out_item_t  res,
  output logic                 advance,
  fsmp_out_if.source           out_ch
);

  logic                valid_r;
  logic                valid_nxt;
  fsmp_pkg::out_item_t res_r;

  // The register takes a new result when empty or when its beat is taken.
  assign advance = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      res_r <= res;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.payload_valid = res_r.payload_valid;
  assign out_ch.payload_byte  = res_r.payload_byte;
  assign out_ch.payload_index = res_r.payload_index;
  assign out_ch.frame_done    = res_r.frame_done;
  assign out_ch.frame_ok      = res_r.frame_ok;
  assign out_ch.frame_seq     = res_r.frame_seq;
  assign out_ch.frame_cmd     = res_r.frame_cmd;
  assign out_ch.frame_length  = res_r.frame_length;

endmodule

>>> rtl/framed_serial_message_parser.sv
// Framed serial message parser: one result beat for every input beat.
// An accepted beat passes through the input register, then the result register, to the result channel.
// Throughput: one beat per cycle while the result channel takes its beats.
// Reset: synchronous, active low; clears phase, counters and sums, and loads the
// configuration defaults (min 2, max 66, idle limit 50). No clearing pass is needed.
module framed_serial_message_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  fsmp_in_if.sink                       in_ch,
  fsmp_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [fsmp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_wdata
);

  fsmp_pkg::cfg_t       cfg;
  fsmp_pkg::in_item_t   s1_item;
  fsmp_pkg::out_item_t  res;
  fsmp_pkg::stage_ctl_t ctl;
  logic                 s1_valid;
  logic                 advance;

  fsmp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fsmp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  assign ctl.valid = s1_valid;
  assign ctl.fire  = advance;

  fsmp_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .item  (s1_item),
    .cfg   (cfg),
    .res   (res)
  );

  fsmp_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .res      (res),
    .advance  (advance),
    .out_ch   (out_ch)
  );

  // A result beat is either a payload byte or a frame report, never both.
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.payload_valid && out_ch.frame_done))
    else $error("payload and frame report in one beat");

  // A good-checksum flag only comes with a frame report.
  a_ok_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.frame_ok) |-> out_ch.frame_done)
    else $error("frame_ok without frame_done");

  // A beat in the input register that moves on always lands in the result register.
  a_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && advance) |=> out_ch.valid)
    else $error("result lost between stages");

  // Reset empties the result register.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

endmodule

>>> tb/fsmp_frame_checker.sv
// Checker for the framed serial message parser: predicts one result beat per input beat.
// Watches the input, result and configuration ports; needs fsmp_pkg and fsmp_ifs.sv.
module fsmp_frame_checker
  import fsmp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  fsmp_in_if                   in_ch,
  fsmp_out_if                  out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata,
  output int                   fail_count,
  output int                   pending
);

  // Shadow copy of the configuration registers.
  logic [7:0] min_len;
  logic [7:0] max_len;
  logic [5:0] idle_lim;

  // Shadow copy of the parser state.
  phase_t     ph;
  logic [7:0] sum_acc;
  logic [7:0] body_cnt;
  logic [7:0] body_len;
  logic [7:0] seq_hold;
  logic [7:0] cmd_hold;
  logic [5:0] idle_cnt;

  out_item_t predicted_beats[$];
  out_item_t want;
  out_item_t got;

  // Advances the shadow parser by one input beat and returns the result it must produce.
  function automatic out_item_t parse_beat(in_item_t b);
    out_item_t r;
    r = '0;
    if (b.op == OP_TICK) begin
      if (idle_cnt < idle_lim) idle_cnt = idle_cnt + 6'd1;
      if (idle_cnt >= idle_lim) ph = PH_HUNT;
      return r;
    end
    idle_cnt = '0;
    case (ph)
      PH_HUNT: begin
        if (b.rx_byte == FRAME_MARK) begin
          ph = PH_LEN;
          sum_acc = '0;
          body_cnt = '0;
        end
      end
      PH_LEN: begin
        if (b.rx_byte < min_len) begin
          ph = PH_HUNT;
        end else if (b.rx_byte <= max_len) begin
          body_len = b.rx_byte - LEN_OVERHEAD;
          sum_acc = sum_acc + b.rx_byte;
          ph = PH_SEQ;
        end else begin
          // Oversized frame: the length itself becomes the skip count.
          body_len = b.rx_byte;
          ph = PH_SKIP;
        end
      end
      PH_SEQ: begin
        seq_hold = b.rx_byte;
        sum_acc = sum_acc + b.rx_byte;
        ph = PH_CMD;
      end
      PH_CMD: begin
        cmd_hold = b.rx_byte;
        sum_acc = sum_acc + b.rx_byte;
        ph = PH_BODY;
      end
      PH_BODY: begin
        if (body_cnt < body_len) begin
          r.payload_valid = 1'b1;
          r.payload_byte = b.rx_byte;
          r.payload_index = body_cnt;
          body_cnt = body_cnt + 8'd1;
          sum_acc = sum_acc + b.rx_byte;
        end else begin
          r.frame_done = 1'b1;
          r.frame_ok = (sum_acc == b.rx_byte);
          r.frame_seq = seq_hold;
          r.frame_cmd = cmd_hold;
          r.frame_length = body_len + LEN_OVERHEAD;
          ph = PH_HUNT;
        end
      end
      PH_SKIP: begin
        if (body_cnt == body_len) ph = PH_HUNT;
        body_cnt = body_cnt + 8'd1;
      end
      default: ph = PH_HUNT;
    endcase
    return r;
  endfunction

  task automatic compare_field(input string fname, input int unsigned exp_v,
                               input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, fname, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Compare result beats first, then apply register writes and predict new input beats.
  always @(posedge clk) begin
    if (!rst_n) begin
      min_len = MIN_LENGTH_RST;
      max_len = MAX_LENGTH_RST;
      idle_lim = IDLE_LIMIT_RST;
      ph = PH_HUNT;
      sum_acc = '0;
      body_cnt = '0;
      body_len = '0;
      seq_hold = '0;
      cmd_hold = '0;
      idle_cnt = '0;
      predicted_beats.delete();
      fail_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.payload_valid, out_ch.payload_byte, out_ch.payload_index,
                out_ch.frame_done, out_ch.frame_ok, out_ch.frame_seq, out_ch.frame_cmd,
                out_ch.frame_length};
        if (predicted_beats.size() == 0) begin
          $display("%0t: result beat with nothing outstanding: expected none, actual 0x%0h",
                   $time, got);
          fail_count++;
        end else begin
          want = predicted_beats.pop_front();
          compare_field("payload_valid", want.payload_valid, got.payload_valid);
          compare_field("payload_byte", want.payload_byte, got.payload_byte);
          compare_field("payload_index", want.payload_index, got.payload_index);
          compare_field("frame_done", want.frame_done, got.frame_done);
          compare_field("frame_ok", want.frame_ok, got.frame_ok);
          compare_field("frame_seq", want.frame_seq, got.frame_seq);
          compare_field("frame_cmd", want.frame_cmd, got.frame_cmd);
          compare_field("frame_length", want.frame_length, got.frame_length);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_LENGTH: min_len = cfg_wdata;
          CFG_MAX_LENGTH: max_len = cfg_wdata;
          CFG_IDLE_LIMIT: idle_lim = cfg_wdata[5:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        predicted_beats.push_back(parse_beat('{in_ch.op, in_ch.rx_byte}));
      end
    end
    pending = predicted_beats.size();
  end

endmodule

>>> tb/tb_framed_serial_message_parser.sv
// Testbench top for the framed serial message parser: clock, reset, stimulus and verdict.
// Drives frames, noise and ticks over several register settings; fsmp_frame_checker judges.
module tb_framed_serial_message_parser;
  import fsmp_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_COUNT = 9;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_wdata;
  int                   fail_count;
  int                   pending;
  int                   cycle_count = 0;
  int                   beats_sent = 0;
  bit                   steady = 1'b0;

  // Current register values, used only to shape the stimulus.
  logic [7:0] cur_min = MIN_LENGTH_RST;
  logic [7:0] cur_max = MAX_LENGTH_RST;
  logic [5:0] cur_idle = IDLE_LIMIT_RST;

  // Register settings per random phase, extremes included.
  int min_tab[PHASE_COUNT]  = '{2, 2, 255, 2, 10, 30, 0, 1, 4};
  int max_tab[PHASE_COUNT]  = '{66, 255, 255, 2, 20, 12, 8, 6, 40};
  int idle_tab[PHASE_COUNT] = '{50, 63, 1, 1, 5, 8, 0, 3, 20};

  fsmp_in_if  in_ch ();
  fsmp_out_if out_ch ();

  framed_serial_message_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  fsmp_frame_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: random stall before each beat, none while steady.
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // One input beat; valid only drops when a gap is drawn.
  task automatic send_beat(input logic op, input logic [7:0] data);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.rx_byte <= data;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
    if (beats_sent % 48 == 0) steady = ($urandom_range(0, 3) == 0);
  endtask

  task automatic send_byte(input logic [7:0] data);
    send_beat(OP_BYTE, data);
  endtask

  // A tick carries a random byte that the parser must ignore.
  task automatic send_ticks(input int count);
    repeat (count) send_beat(OP_TICK, 8'($urandom));
  endtask

  // Complete frame; ticks may be slipped in between payload bytes.
  task automatic send_frame(input logic [7:0] len, input logic [7:0] seq,
                            input logic [7:0] cmd, input bit corrupt, input bit with_ticks);
    logic [7:0] sum;
    logic [7:0] body_n;
    logic [7:0] pay;
    int i;
    sum = len + seq + cmd;
    body_n = len - LEN_OVERHEAD;
    send_byte(FRAME_MARK);
    send_byte(len);
    send_byte(seq);
    send_byte(cmd);
    for (i = 0; i < int'(body_n); i++) begin
      if (with_ticks && $urandom_range(0, 15) == 0) send_ticks($urandom_range(1, cur_idle));
      pay = 8'($urandom);
      sum = sum + pay;
      send_byte(pay);
    end
    send_byte(corrupt ? (sum ^ (8'd1 << $urandom_range(0, 7))) : sum);
  endtask

  // Oversized frame: the parser swallows L+1 bytes after the length.
  task automatic send_skipped(input logic [7:0] len);
    send_byte(FRAME_MARK);
    send_byte(len);
    repeat (int'(len) + 1) send_byte(8'($urandom));
  endtask

  // Three back-to-back register writes with the enable held high.
  task automatic write_regs(input logic [7:0] lo, input logic [7:0] hi, input logic [5:0] lim);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MIN_LENGTH;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= CFG_MAX_LENGTH;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_index <= CFG_IDLE_LIMIT;
    cfg_wdata <= {2'b00, lim};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_min = lo;
    cur_max = hi;
    cur_idle = lim;
  endtask

  // Hold off input until every predicted beat has come back.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly well-formed frames, the rest skips, short lengths, noise, ticks and cut frames.
  task automatic run_phase(input int budget);
    int start;
    int kind;
    int lo;
    int hi;
    int span;
    int floor_len;
    logic [7:0] len;
    lo = cur_min;
    hi = cur_max;
    start = beats_sent;
    while (beats_sent - start < budget) begin
      kind = $urandom_range(0, 99);
      floor_len = (lo > hi) ? lo : hi + 1;
      if (kind < 60 && lo <= hi) begin
        span = hi - lo;
        if ($urandom_range(0, 7) == 0) len = 8'(lo + $urandom_range(0, span));
        else len = 8'(lo + $urandom_range(0, (span < 6) ? span : 6));
        send_frame(len, 8'($urandom), 8'($urandom), $urandom_range(0, 4) == 0, 1'b1);
      end else if (kind < 70 && floor_len <= 255) begin
        len = 8'(floor_len + $urandom_range(0, (255 - floor_len < 6) ? 255 - floor_len : 6));
        send_skipped(len);
      end else if (kind < 78 && lo > 0) begin
        send_byte(FRAME_MARK);
        send_byte(8'($urandom_range(0, lo - 1)));
      end else if (kind < 88) begin
        repeat ($urandom_range(1, 6)) begin
          send_byte(($urandom_range(0, 3) == 0) ? FRAME_MARK : 8'($urandom));
        end
      end else if (kind < 94) begin
        send_ticks($urandom_range(1, int'(cur_idle) + 3));
      end else begin
        // Frame cut short by the idle timeout.
        send_byte(FRAME_MARK);
        send_byte(8'((lo <= hi) ? lo + $urandom_range(0, (hi - lo < 6) ? hi - lo : 6) : 2));
        repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
        send_ticks(int'(cur_idle) + 1);
      end
    end
  endtask

  initial begin : stimulus
    int p;
    in_ch.valid <= 1'b0;
    in_ch.op <= OP_BYTE;
    in_ch.rx_byte <= 8'h00;
    cfg_we <= 1'b0;
    cfg_index <= CFG_MIN_LENGTH;
    cfg_wdata <= 8'h00;
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats on reset settings: noise, tick, empty frame, bad checksum, short length, good frame.
    send_byte(8'hFF);
    send_beat(OP_TICK, 8'hFF);
    send_beat(OP_TICK, 8'h00);
    send_frame(8'd2, 8'hFF, 8'h00, 1'b0, 1'b0);
    send_frame(8'd4, 8'h00, 8'hFF, 1'b1, 1'b0);
    send_byte(FRAME_MARK);
    send_byte(8'd1);
    send_byte(FRAME_MARK);
    send_byte(8'd0);
    send_frame(8'd3, 8'h5A, 8'hA5, 1'b0, 1'b0);
    settle();

    // Random phases, each under its own register setting; long frames overrun the budget.
    for (p = 0; p < PHASE_COUNT; p++) begin
      write_regs(8'(min_tab[p]), 8'(max_tab[p]), 6'(idle_tab[p]));
      run_phase(40);
      settle();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
